@@ hdl/umcd_pkg.sv @@
// shared types, constants and decode functions for the motion command decoder
package umcd_pkg;

  // frame buffer geometry
  localparam int unsigned FrameDepth = 5;
  localparam int unsigned IdxWidth   = $clog2(FrameDepth + 1);

  // frame terminator and command letter range
  localparam logic [7:0] CharEnd   = 8'h3A;
  localparam logic [7:0] CharA     = 8'h61;
  localparam logic [7:0] CharM     = 8'h6D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  // motor drive codes
  localparam logic [1:0] DriveCoast   = 2'd0;
  localparam logic [1:0] DriveForward = 2'd1;
  localparam logic [1:0] DriveReverse = 2'd2;
  localparam logic [1:0] DriveBrake   = 2'd3;

  // command offsets from the letter 'a'
  localparam logic [3:0] CmdA = 4'd0;
  localparam logic [3:0] CmdB = 4'd1;
  localparam logic [3:0] CmdC = 4'd2;
  localparam logic [3:0] CmdD = 4'd3;
  localparam logic [3:0] CmdE = 4'd4;
  localparam logic [3:0] CmdF = 4'd5;
  localparam logic [3:0] CmdG = 4'd6;
  localparam logic [3:0] CmdH = 4'd7;
  localparam logic [3:0] CmdI = 4'd8;
  localparam logic [3:0] CmdJ = 4'd9;
  localparam logic [3:0] CmdK = 4'd10;
  localparam logic [3:0] CmdL = 4'd11;
  localparam logic [3:0] CmdM = 4'd12;

  // where the duty values come from
  typedef enum logic [1:0] {
    DutyKeep   = 2'd0,
    DutyPair   = 2'd1,
    DutyShared = 2'd2
  } duty_mode_e;

  typedef logic [FrameDepth-1:0][7:0] frame_t;

  // four drive codes, lf lr rf rr
  typedef struct packed {
    logic [1:0] lf;
    logic [1:0] lr;
    logic [1:0] rf;
    logic [1:0] rr;
  } drive_t;

  typedef struct packed {
    drive_t     drive;
    duty_mode_e mode;
  } motion_t;

  // held motion state
  typedef struct packed {
    drive_t     drive;
    logic       led;
    logic [6:0] pwm_left;
    logic [6:0] pwm_right;
  } motion_state_t;

  // one result item
  typedef struct packed {
    motion_state_t state;
    logic          known;
  } result_t;

  // motion table lookup by offset from 'a'
  function automatic motion_t motion_lookup(input logic [3:0] cmd);
    motion_t m;
    unique case (cmd)
      CmdA:    m = '{'{DriveBrake, DriveBrake, DriveBrake, DriveBrake}, DutyKeep};
      CmdB:    m = '{'{DriveForward, DriveForward, DriveForward, DriveForward}, DutyPair};
      CmdC:    m = '{'{DriveReverse, DriveReverse, DriveReverse, DriveReverse}, DutyPair};
      CmdD:    m = '{'{DriveForward, DriveReverse, DriveReverse, DriveForward}, DutyPair};
      CmdE:    m = '{'{DriveReverse, DriveForward, DriveForward, DriveReverse}, DutyPair};
      CmdF:    m = '{'{DriveForward, DriveCoast, DriveCoast, DriveForward}, DutyShared};
      CmdG:    m = '{'{DriveCoast, DriveForward, DriveForward, DriveCoast}, DutyShared};
      CmdH:    m = '{'{DriveCoast, DriveReverse, DriveReverse, DriveCoast}, DutyShared};
      CmdI:    m = '{'{DriveReverse, DriveCoast, DriveCoast, DriveReverse}, DutyShared};
      CmdJ:    m = '{'{DriveForward, DriveForward, DriveReverse, DriveReverse}, DutyShared};
      CmdK:    m = '{'{DriveReverse, DriveReverse, DriveForward, DriveForward}, DutyShared};
      CmdL:    m = '{'{DriveReverse, DriveCoast, DriveForward, DriveCoast}, DutyPair};
      CmdM:    m = '{'{DriveForward, DriveCoast, DriveReverse, DriveCoast}, DutyPair};
      default: m = '{'{DriveBrake, DriveBrake, DriveBrake, DriveBrake}, DutyKeep};
    endcase
    return m;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  // leading decimal digits of a two-byte group, 0 to 99
  function automatic logic [6:0] parse_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [6:0] hi_v;
    logic [6:0] lo_v;
    logic [6:0] val;
    hi_v = {3'b000, hi[3:0]};
    lo_v = {3'b000, lo[3:0]};
    if (!is_digit(hi)) begin
      val = 7'd0;
    end else if (!is_digit(lo)) begin
      val = hi_v;
    end else begin
      // times ten as shift and add
      val = (hi_v << 3) + (hi_v << 1) + lo_v;
    end
    return val;
  endfunction

endpackage

@@ hdl/umcd_decode.sv @@
// frame decoder: letter lookup and duty parsing against the held motion state
module umcd_decode (
  input  umcd_pkg::frame_t        frame_i,
  input  umcd_pkg::motion_state_t held_i,
  output umcd_pkg::result_t       result_o
);
  import umcd_pkg::*;

  logic       known;
  logic [3:0] cmd;
  motion_t    motion;
  logic [6:0] duty_a;
  logic [6:0] duty_b;

  // letter range check and table lookup
  assign known  = (frame_i[0] >= CharA) && (frame_i[0] <= CharM);
  assign cmd    = 4'(frame_i[0] - CharA);
  assign motion = motion_lookup(cmd);

  // duty groups from bytes 1-2 and 3-4
  assign duty_a = parse_pair(frame_i[1], frame_i[2]);
  assign duty_b = parse_pair(frame_i[3], frame_i[4]);

  // new state, or held state for an unknown letter
  always_comb begin
    result_o.state = held_i;
    result_o.known = known;
    if (known) begin
      result_o.state.drive = motion.drive;
      result_o.state.led   = (motion.mode != DutyKeep);
      case (motion.mode)
        DutyPair: begin
          result_o.state.pwm_left  = duty_a;
          result_o.state.pwm_right = duty_b;
        end
        DutyShared: begin
          result_o.state.pwm_left  = duty_a;
          result_o.state.pwm_right = duty_a;
        end
        default: begin
          result_o.state.pwm_left  = held_i.pwm_left;
          result_o.state.pwm_right = held_i.pwm_right;
        end
      endcase
    end
  end

endmodule

@@ hdl/uart_motion_command_decoder.sv @@
// Motion command decoder top level: takes one received byte per cycle. Every
// byte passes an input register; the first five bytes of a frame are merged
// into the five-byte frame buffer. A ':' byte also loads the result register
// and clears the buffer, so a result reaches the outputs through the input
// register and the result register. The rate is
// one byte per cycle; ready drops only while a terminator waits in the input
// register behind a result that has not been taken yet.
module uart_motion_command_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic [1:0] motor_left_front_o,
  output logic [1:0] motor_left_rear_o,
  output logic [1:0] motor_right_front_o,
  output logic [1:0] motor_right_rear_o,
  output logic       led_on_o,
  output logic [6:0] pwm_left_o,
  output logic [6:0] pwm_right_o,
  output logic       command_known_o
);
  import umcd_pkg::*;

  logic                in_valid_q;
  logic [7:0]          in_byte_q;
  frame_t              frame_q, frame_d, frame_eff;
  logic [IdxWidth-1:0] widx_q, widx_d;
  motion_state_t       state_q, state_d;
  logic                out_valid_q, out_valid_d;
  result_t             out_q, out_d;
  result_t             dec_result;
  logic                is_end;
  logic                advance;

  // stage handshake
  assign is_end     = (in_byte_q == CharEnd);
  assign advance    = in_valid_q && (!is_end || !out_valid_q || res_ready_i);
  assign rx_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_ready_o) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_ready_o && rx_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // frame buffer with the current byte written in
  always_comb begin
    for (int i = 0; i < FrameDepth; i++) begin
      frame_eff[i] = (widx_q == IdxWidth'(i)) ? in_byte_q : frame_q[i];
    end
  end

  umcd_decode u_decode (
    .frame_i  (frame_eff),
    .held_i   (state_q),
    .result_o (dec_result)
  );

  // next frame, index, motion state and result
  always_comb begin
    frame_d     = frame_q;
    widx_d      = widx_q;
    state_d     = state_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_ready_i;
    if (advance) begin
      if (is_end) begin
        frame_d     = '0;
        widx_d      = '0;
        state_d     = dec_result.state;
        out_d       = dec_result;
        out_valid_d = 1'b1;
      end else begin
        frame_d = frame_eff;
        if (widx_q < IdxWidth'(FrameDepth)) begin
          widx_d = widx_q + 1'b1;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q     <= '0;
      widx_q      <= '0;
      state_q     <= '{'{DriveBrake, DriveBrake, DriveBrake, DriveBrake}, 1'b0, 7'd0, 7'd0};
      out_valid_q <= 1'b0;
    end else begin
      frame_q     <= frame_d;
      widx_q      <= widx_d;
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_valid_o         = out_valid_q;
  assign motor_left_front_o  = out_q.state.drive.lf;
  assign motor_left_rear_o   = out_q.state.drive.lr;
  assign motor_right_front_o = out_q.state.drive.rf;
  assign motor_right_rear_o  = out_q.state.drive.rr;
  assign led_on_o            = out_q.state.led;
  assign pwm_left_o          = out_q.state.pwm_left;
  assign pwm_right_o         = out_q.state.pwm_right;
  assign command_known_o     = out_q.known;

endmodule

@@ tb/uart_motion_command_decoder_tb.sv @@
// self-checking testbench for the motion command decoder: byte streams in, decoded motions checked
`timescale 1ns / 1ps

module uart_motion_command_decoder_tb;
  import umcd_pkg::*;

  localparam int unsigned CycleLimit  = 100000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned MaxPrinted  = 40;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       rx_valid_i = 1'b0;
  logic       rx_ready_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       res_valid_o;
  logic       res_ready_i = 1'b0;
  logic [1:0] motor_left_front_o;
  logic [1:0] motor_left_rear_o;
  logic [1:0] motor_right_front_o;
  logic [1:0] motor_right_rear_o;
  logic       led_on_o;
  logic [6:0] pwm_left_o;
  logic [6:0] pwm_right_o;
  logic       command_known_o;

  // shadow of the decoder state
  logic [7:0]    frame_shadow [FrameDepth];
  int unsigned   frame_fill;
  motion_state_t motion_now;
  result_t       pending_motion_q [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;

  uart_motion_command_decoder dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .rx_valid_i          (rx_valid_i),
    .rx_ready_o          (rx_ready_o),
    .rx_byte_i           (rx_byte_i),
    .res_valid_o         (res_valid_o),
    .res_ready_i         (res_ready_i),
    .motor_left_front_o  (motor_left_front_o),
    .motor_left_rear_o   (motor_left_rear_o),
    .motor_right_front_o (motor_right_front_o),
    .motor_right_rear_o  (motor_right_rear_o),
    .led_on_o            (led_on_o),
    .pwm_left_o          (pwm_left_o),
    .pwm_right_o         (pwm_right_o),
    .command_known_o     (command_known_o)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL uart_motion_command_decoder");
      $finish;
    end
  end

  // motor pattern per command, order lf lr rf rr
  function automatic string motion_pattern(input logic [3:0] cmd);
    case (cmd)
      CmdA:    return "BBBB";
      CmdB:    return "FFFF";
      CmdC:    return "RRRR";
      CmdD:    return "FRRF";
      CmdE:    return "RFFR";
      CmdF:    return "FCCF";
      CmdG:    return "CFFC";
      CmdH:    return "CRRC";
      CmdI:    return "RCCR";
      CmdJ:    return "FFRR";
      CmdK:    return "RRFF";
      CmdL:    return "RCFC";
      default: return "FCRC";
    endcase
  endfunction

  function automatic logic [1:0] drive_code(input byte c);
    if (c == "F") return DriveForward;
    if (c == "R") return DriveReverse;
    if (c == "C") return DriveCoast;
    return DriveBrake;
  endfunction

  // which frame bytes feed the duty values
  function automatic duty_mode_e duty_source(input logic [3:0] cmd);
    case (cmd)
      CmdA:                               return DutyKeep;
      CmdF, CmdG, CmdH, CmdI, CmdJ, CmdK: return DutyShared;
      default:                            return DutyPair;
    endcase
  endfunction

  function automatic bit is_decimal(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  // leading decimal digits of a two-byte group
  function automatic logic [6:0] leading_digits(input logic [7:0] hi, input logic [7:0] lo);
    int unsigned v;
    if (!is_decimal(hi)) return 7'd0;
    v = hi - CharZero;
    if (is_decimal(lo)) v = v * 10 + (lo - CharZero);
    return 7'(v);
  endfunction

  task automatic clear_frame();
    foreach (frame_shadow[k]) frame_shadow[k] = 8'h00;
    frame_fill = 0;
  endtask

  // update the shadow with one transferred byte and queue the motion it causes
  task automatic predict_motion(input logic [7:0] b);
    logic [3:0] cmd;
    string      pattern;
    duty_mode_e mode;
    result_t    res;
    if (frame_fill < FrameDepth) begin
      frame_shadow[frame_fill] = b;
      frame_fill++;
    end
    if (b != CharEnd) return;
    res.known = 1'b0;
    if (frame_shadow[0] >= CharA && frame_shadow[0] <= CharM) begin
      cmd = 4'(frame_shadow[0] - CharA);
      pattern = motion_pattern(cmd);
      mode = duty_source(cmd);
      motion_now.drive.lf = drive_code(pattern[0]);
      motion_now.drive.lr = drive_code(pattern[1]);
      motion_now.drive.rf = drive_code(pattern[2]);
      motion_now.drive.rr = drive_code(pattern[3]);
      motion_now.led = (mode != DutyKeep);
      if (mode == DutyPair) begin
        motion_now.pwm_left  = leading_digits(frame_shadow[1], frame_shadow[2]);
        motion_now.pwm_right = leading_digits(frame_shadow[3], frame_shadow[4]);
      end else if (mode == DutyShared) begin
        motion_now.pwm_left  = leading_digits(frame_shadow[1], frame_shadow[2]);
        motion_now.pwm_right = motion_now.pwm_left;
      end
      res.known = 1'b1;
    end
    res.state = motion_now;
    pending_motion_q.push_back(res);
    clear_frame();
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MaxPrinted)
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    error_count++;
  endtask

  // sender: one byte per transfer, random gaps after it
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    predict_motion(b);
    bytes_sent++;
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      rx_valid_i <= 1'b0;
      rx_byte_i  <= 8'($urandom);
      while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // mostly well-formed frames with random content, some noise and broken frames
  task automatic send_random_frame();
    int unsigned kind;
    int unsigned body_len;
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
    end else begin
      if ($urandom_range(99) < 85) send_byte(8'($urandom_range(CharM, CharA)));
      else send_byte(8'($urandom));
      body_len = $urandom_range(7);
      repeat (body_len) begin
        if ($urandom_range(99) < 75) send_byte(8'($urandom_range(CharNine, CharZero)));
        else send_byte(8'($urandom));
      end
      send_byte(CharEnd);
    end
  endtask

  task automatic send_random_frames(input int unsigned n_items);
    int unsigned target;
    target = bytes_sent + n_items;
    while (bytes_sent < target) send_random_frame();
  endtask

  // receiver: random stalls, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      res_ready_i <= 1'b0;
      hold_cycles--;
    end else begin
      res_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // compare every result transfer with the oldest predicted motion
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && res_valid_o && res_ready_i) begin
      if (pending_motion_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_motion_q.pop_front();
        if (motor_left_front_o !== want.state.drive.lf)
          report_mismatch("motor_left_front", motor_left_front_o, want.state.drive.lf);
        if (motor_left_rear_o !== want.state.drive.lr)
          report_mismatch("motor_left_rear", motor_left_rear_o, want.state.drive.lr);
        if (motor_right_front_o !== want.state.drive.rf)
          report_mismatch("motor_right_front", motor_right_front_o, want.state.drive.rf);
        if (motor_right_rear_o !== want.state.drive.rr)
          report_mismatch("motor_right_rear", motor_right_rear_o, want.state.drive.rr);
        if (led_on_o !== want.state.led)
          report_mismatch("led_on", led_on_o, want.state.led);
        if (pwm_left_o !== want.state.pwm_left)
          report_mismatch("pwm_left", pwm_left_o, want.state.pwm_left);
        if (pwm_right_o !== want.state.pwm_right)
          report_mismatch("pwm_right", pwm_right_o, want.state.pwm_right);
        if (command_known_o !== want.known)
          report_mismatch("command_known", command_known_o, want.known);
      end
    end
  end

  // unknown first frame keeps the reset motion
  task automatic test_reset_hold();
    send_text(":");
  endtask

  // widest and narrowest duty values, then stop
  task automatic test_duty_extremes();
    send_text("b9900:");
    send_text("a:");
  endtask

  // spaces, signs, short frames and bytes at the ends of the range
  task automatic test_duty_parsing();
    send_text("c7 +5:");
    send_text("d:");
    send_text("l");
    send_byte(8'hFF);
    send_byte(8'h00);
    send_text("8:");
  endtask

  // bytes past the fifth are dropped, shared duty from the first group
  task automatic test_long_frame();
    send_text("m12345:");
    send_text("f4212:");
  endtask

  // remaining motions
  task automatic test_all_motions();
    send_text("e:");
    send_text("g1:");
    send_text("h:");
    send_text("i3x:");
    send_text("j:");
    send_text("k:");
  endtask

  // receiver holds off for a long stretch while frames keep coming
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 400;
    send_random_frames(150);
  endtask

  task automatic test_random_phase(input int unsigned sender_idle, input int unsigned recv_stall);
    idle_pct = sender_idle;
    stall_pct = recv_stall;
    send_random_frames(275);
  endtask

  initial begin
    motion_now.drive = '{DriveBrake, DriveBrake, DriveBrake, DriveBrake};
    motion_now.led = 1'b0;
    motion_now.pwm_left = 7'd0;
    motion_now.pwm_right = 7'd0;
    clear_frame();

    // reset
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_hold();
    test_duty_extremes();
    test_duty_parsing();
    test_long_frame();
    test_all_motions();
    test_backpressure();
    test_random_phase(0, 0);
    test_random_phase(50, 0);
    test_random_phase(0, 50);
    test_random_phase(37, 37);

    @(negedge clk_i);
    rx_valid_i <= 1'b0;

    // drain
    while (pending_motion_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("PASS uart_motion_command_decoder");
    end else begin
      $display("FAIL uart_motion_command_decoder");
    end
    $finish;
  end

endmodule
